// ===== rtl/uwalk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwalk_pkg
// shared types and constants for the descriptor walker
// ----------------------------------------------------------------------------
package uwalk_pkg;

    localparam int unsigned POS_W     = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ERR_W     = 2;
    localparam int unsigned OUT_W     = 56;

    localparam logic [BYTE_W-1:0] MIN_DESC_LEN = 8'd2;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNCATED = 2'd1,
        ERR_ZERO_LEN  = 2'd2
    } t_err;

    typedef struct packed {
        logic              at_end;
        t_err              error_code;
        logic [BYTE_W-1:0] byte_out;
        logic              byte_valid;
        logic [BYTE_W-1:0] rel_offset;
        logic [BYTE_W-1:0] desc_type;
        logic [BYTE_W-1:0] desc_length;
        logic [POS_W-1:0]  desc_offset;
        logic              desc_found;
    } t_result;

endpackage

// ===== rtl/uwalk_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uwalk_core
// walk state and per-byte header checks, one beat per enabled cycle
// ----------------------------------------------------------------------------
module uwalk_core import uwalk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [POS_W-1:0]  i_total,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_restart,
    output t_result           o_res
);

    logic [POS_W-1:0]  r_pos, n_pos;
    t_err              r_err, n_err;
    logic [POS_W-1:0]  r_start, n_start;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_type, n_type;

    logic [POS_W-1:0]  e_pos, e_start;
    t_err              e_err;
    logic [BYTE_W-1:0] e_len, e_type;
    logic [POS_W:0]    room;
    logic [POS_W-1:0]  rel;
    logic [POS_W:0]    rel_inc;

    always_comb begin
        e_pos   = i_restart ? '0 : r_pos;
        e_err   = i_restart ? ERR_NONE : r_err;
        e_start = i_restart ? '0 : r_start;
        e_len   = i_restart ? '0 : r_len;
        e_type  = i_restart ? '0 : r_type;

        room    = {1'b0, i_total} - {1'b0, e_pos};
        rel     = e_pos - e_start;
        rel_inc = {1'b0, rel} + {{POS_W{1'b0}}, 1'b1};

        n_pos   = e_pos;
        n_err   = e_err;
        n_start = e_start;
        n_len   = e_len;
        n_type  = e_type;

        o_res            = '0;
        o_res.byte_out   = i_data;

        if (e_err != ERR_NONE) begin
            // sticky error, hold position
        end else if (e_pos >= i_total) begin
            o_res.at_end = 1'b1;
        end else if (e_len == '0) begin
            if (room < {{(POS_W+1-BYTE_W){1'b0}}, MIN_DESC_LEN}) begin
                n_err = ERR_TRUNCATED;
            end else if (i_data < MIN_DESC_LEN) begin
                n_err = ERR_ZERO_LEN;
            end else if ({{(POS_W+1-BYTE_W){1'b0}}, i_data} > room) begin
                n_err = ERR_TRUNCATED;
            end else begin
                n_start           = e_pos;
                n_len             = i_data;
                n_type            = '0;
                n_pos             = e_pos + POS_W'(1);
                o_res.byte_valid  = 1'b1;
                o_res.desc_offset = e_pos;
                o_res.desc_length = i_data;
            end
        end else begin
            if (rel == 16'd1) begin
                n_type           = i_data;
                o_res.desc_found = 1'b1;
            end
            o_res.byte_valid  = 1'b1;
            o_res.desc_offset = e_start;
            o_res.desc_length = e_len;
            o_res.desc_type   = (rel == 16'd1) ? i_data : e_type;
            o_res.rel_offset  = rel[BYTE_W-1:0];
            n_pos             = e_pos + POS_W'(1);
            if (rel_inc >= {{(POS_W+1-BYTE_W){1'b0}}, e_len}) begin
                n_len = '0;
            end
        end
        o_res.error_code = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_err   <= ERR_NONE;
            r_start <= '0;
            r_len   <= '0;
            r_type  <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_start <= n_start;
            r_len   <= n_len;
            r_type  <= n_type;
        end
    end

    a_err_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_restart && r_err != ERR_NONE) |=> $stable(r_pos))
        else $error("position moved while error set");

    a_valid_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.byte_valid) |-> (o_res.error_code == ERR_NONE && !o_res.at_end))
        else $error("valid byte with error or end");

    a_found_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.desc_found) |-> (o_res.rel_offset == 8'd1 && o_res.byte_valid))
        else $error("descriptor found off the type byte");

    a_step_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.byte_valid) |=> (r_pos == $past(n_pos) && r_pos != '0))
        else $error("position not advanced on valid byte");

endmodule

// ===== rtl/usb_descriptor_walker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_descriptor_walker_top
// splits a descriptor buffer into length-prefixed descriptors, one byte a beat
// path: input register, then the walk core and the result register
// throughput: one beat per cycle while m_axis_tready does not stall the result register
// reset: synchronous active-low, clears walk state, total length and the valid flags of both stages
// ----------------------------------------------------------------------------
module usb_descriptor_walker_top import uwalk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [POS_W-1:0]  i_cfg_wr_data,   // total_length
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,    // [7:0] data_byte
    input  logic              s_axis_tuser,    // [0] restart
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] desc_found, [16:1] desc_offset, [24:17] desc_length, [32:25] desc_type,
    // [40:33] rel_offset, [41] byte_valid, [49:42] byte_out, [51:50] error_code,
    // [52] at_end, [55:53] zero
    output logic [OUT_W-1:0]  m_axis_tdata
);

    logic [POS_W-1:0]  r_total;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_data;
    logic              r_in_restart;
    logic              r_out_valid;
    t_result           r_out;
    t_result           step_res;
    logic              advance;
    logic              step;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_wr_en) begin
            r_total <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser;
        end
    end

    uwalk_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_total   (r_total),
        .i_data    (r_in_data),
        .i_restart (r_in_restart),
        .o_res     (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

endmodule
